// File: sv/real_cepstrum_fft_unit_macros.svh
// Assertion macros for the real cepstrum FFT unit.
`ifndef REAL_CEPSTRUM_FFT_UNIT_MACROS_SVH
`define REAL_CEPSTRUM_FFT_UNIT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define RCF_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Implication checked at every clock edge outside reset
`define RCF_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with the consequent checked in the next cycle
`define RCF_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rcf_pkg.sv
// Package: types, constants and tables of the real cepstrum FFT unit.
`default_nettype none
package rcf_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int DW             = 40;   // working width of FFT data
    localparam logic [2:0] PTS_LOG2_RESET = 3'd6;

    typedef struct packed {
        logic signed [15:0] sample_re;
        logic signed [15:0] sample_im;
        logic               frame_last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] coef_re;
        logic signed [31:0] coef_im;
        logic               coef_last;
    } t_out_item;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
    } t_cplx;

    // Quarter-wave cosine table, Q1.15
    function automatic logic signed [16:0] cos_tab(input logic [4:0] t);
        logic signed [16:0] v;
        case (t)
            5'd0:  v = 17'sd32768;
            5'd1:  v = 17'sd32610;
            5'd2:  v = 17'sd32138;
            5'd3:  v = 17'sd31357;
            5'd4:  v = 17'sd30274;
            5'd5:  v = 17'sd28899;
            5'd6:  v = 17'sd27245;
            5'd7:  v = 17'sd25330;
            5'd8:  v = 17'sd23170;
            5'd9:  v = 17'sd20788;
            5'd10: v = 17'sd18205;
            5'd11: v = 17'sd15447;
            5'd12: v = 17'sd12540;
            5'd13: v = 17'sd9512;
            5'd14: v = 17'sd6393;
            5'd15: v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // cos(2*pi*t/64) in Q1.15
    function automatic logic signed [16:0] cos64(input logic [5:0] t);
        logic signed [16:0] v;
        if (t <= 6'd16) begin
            v = cos_tab(t[4:0]);
        end else if (t <= 6'd32) begin
            v = -cos_tab(5'(6'd32 - t));
        end else if (t <= 6'd48) begin
            v = -cos_tab(5'(t - 6'd32));
        end else begin
            v = cos_tab(5'(7'd64 - {1'b0, t}));
        end
        return v;
    endfunction

    // log2(1 + k/16) in Q16
    function automatic logic [16:0] log2_tab(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:  v = 17'd0;
            5'd1:  v = 17'd5732;
            5'd2:  v = 17'd11136;
            5'd3:  v = 17'd16248;
            5'd4:  v = 17'd21098;
            5'd5:  v = 17'd25711;
            5'd6:  v = 17'd30109;
            5'd7:  v = 17'd34312;
            5'd8:  v = 17'd38336;
            5'd9:  v = 17'd42196;
            5'd10: v = 17'd45904;
            5'd11: v = 17'd49472;
            5'd12: v = 17'd52911;
            5'd13: v = 17'd56229;
            5'd14: v = 17'd59434;
            5'd15: v = 17'd62534;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: sv/real_cepstrum_fft_unit.sv
// Real cepstrum unit: frame load, forward FFT, log magnitude, inverse FFT, readout.
//
//  channel  direction  handshake            payload
//  in       input      i_in_valid/o_in_stall   i_in_data  (t_in_item)
//  out      output     o_out_valid/i_out_stall o_out_data (t_out_item)
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_data (points_log2)
//
// Loading takes one cycle per sample. After the sample flagged last, a copy pass
// moves the frame into bit-reversed order, then one shared multiplier runs each
// butterfly in turn, (N/2)*log2(N) butterflies in each FFT. The log pass treats a
// zero bin apart and else runs a leading-one search. Readout shows each coefficient
// and holds it through any output stall until it transfers.
// Reset is synchronous; it clears the control state, memory contents stay.
// Input is stalled from the last sample until the final coefficient transfers.
`default_nettype none
module real_cepstrum_fft_unit
    import rcf_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [2:0] i_cfg_data
);
    `include "real_cepstrum_fft_unit_macros.svh"

    localparam int IW = $clog2(MAX_POINTS);
    localparam int AW = IW + 1;
    localparam logic [2:0] LG_MAX = 3'(IW);

    typedef enum logic [4:0] {
        S_IDLE, S_CRD, S_CWR, S_RA, S_RB, S_BF0, S_BF1, S_BF2, S_BF3, S_BF4, S_BF5,
        S_WA, S_WB, S_LRD, S_LSQ0, S_LSQ1, S_LSQ2, S_LNRM, S_LFR0, S_LFR1, S_LLN0,
        S_LLN1, S_LWN, S_ORD, S_OWT, S_OHLD
    } t_state;

    // Frame memory: bank 0 holds the forward FFT, bank 1 the inverse
    t_cplx mem [0:2*MAX_POINTS-1];

    // Sample store in arrival order, kept across frames
    logic [31:0] smp [0:MAX_POINTS-1];

    t_state                r_state;
    logic [2:0]            r_pts_log2;
    logic [IW:0]           r_load;
    logic [IW-1:0]         r_bf;
    logic [IW-1:0]         r_idx;
    logic [2:0]            r_stage;
    logic                  r_inv;
    t_cplx                 r_rd;
    logic [31:0]           r_smp_rd;
    t_cplx                 r_a;
    t_cplx                 r_b;
    logic signed [63:0]    r_prod;
    logic signed [63:0]    r_acc;
    logic signed [DW-1:0]  r_tr;
    logic signed [DW-1:0]  r_ti;
    logic [45:0]           r_norm;
    logic [5:0]            r_e;
    logic signed [23:0]    r_l2;
    logic                  r_ov;
    t_out_item             r_out;

    logic [2:0]            lg;
    logic [IW:0]           n_pts;
    logic [IW:0]           half;
    logic [IW-1:0]         addr_a;
    logic [IW-1:0]         addr_b;
    logic [IW-1:0]         jj;
    logic [10:0]           t_wide;
    logic [5:0]            tw;
    logic signed [16:0]    wr;
    logic signed [16:0]    ws;
    logic signed [16:0]    wi;
    logic [AW-1:0]         rd_addr;
    logic                  we;
    logic [AW-1:0]         wr_addr;
    t_cplx                 wr_data;
    logic                  smp_we;
    logic signed [DW-1:0]  mul_a;
    logic signed [23:0]    mul_b;
    logic                  bf_last;
    logic                  stage_last;
    logic                  idx_last;
    logic                  in_xfer;
    logic                  out_xfer;
    logic [45:0]           m2;
    logic [3:0]            fk;
    logic [16:0]           t_lo;
    logic [16:0]           t_hi;
    logic [16:0]           frac;
    logic signed [63:0]    ln_full;
    logic signed [DW:0]    o_sum_re;
    logic signed [DW:0]    o_sum_im;
    logic signed [DW:0]    o_q_re;
    logic signed [DW:0]    o_q_im;

    // Index reversal over lg bits
    function automatic logic [IW-1:0] bit_rev(input logic [IW-1:0] i, input logic [2:0] l);
        logic [IW-1:0] r;
        for (int b = 0; b < IW; b++) begin
            r[IW-1-b] = i[b];
        end
        return r >> (LG_MAX - l);
    endfunction

    // Round half up and divide by 2^15
    function automatic logic signed [DW-1:0] rnd15(input logic signed [63:0] v);
        logic signed [63:0] x;
        x = (v + 64'sd16384) >>> 15;
        return x[DW-1:0];
    endfunction

    // Saturate to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [DW:0] v);
        logic signed [31:0] r;
        if (v > (DW+1)'(64'sd2147483647)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -(DW+1)'(64'sd2147483648)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Effective frame length
    always_comb begin
        lg = r_pts_log2;
        if (lg < 3'd1) lg = 3'd1;
        if (lg > LG_MAX) lg = LG_MAX;
        n_pts = (IW+1)'(1) << lg;
    end

    // Butterfly addressing and twiddle
    always_comb begin
        half    = (IW+1)'(1) << r_stage;
        jj      = r_bf & (half[IW-1:0] - IW'(1));
        addr_a  = IW'((({1'b0, r_bf} >> r_stage) << (r_stage + 3'd1))) | jj;
        addr_b  = addr_a | half[IW-1:0];
        t_wide  = (11'(jj) << 5) >> r_stage;
        tw      = t_wide[5:0];
        wr      = cos64(tw);
        ws      = cos64(tw + 6'd48);
        wi      = r_inv ? ws : -ws;
        bf_last    = ({1'b0, r_bf} == ((n_pts >> 1) - (IW+1)'(1)));
        stage_last = (r_stage == lg - 3'd1);
        idx_last   = ({1'b0, r_idx} == (n_pts - (IW+1)'(1)));
    end

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_ov && !i_out_stall;
    assign smp_we      = in_xfer && (r_load < n_pts);

    // Sample store: write on load, registered read for the copy pass
    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            smp[r_load[IW-1:0]] <= {i_in_data.sample_im, i_in_data.sample_re};
        end
        r_smp_rd <= smp[r_idx];
    end

    // Memory port control
    always_comb begin
        rd_addr = {r_inv, addr_a};
        we      = 1'b0;
        wr_addr = {r_inv, addr_a};
        wr_data = '{re: r_a.re + r_tr, im: r_a.im + r_ti};
        case (r_state)
            S_CWR: begin
                we      = 1'b1;
                wr_addr = {1'b0, bit_rev(r_idx, lg)};
                wr_data = '{re: DW'($signed(r_smp_rd[15:0])),
                            im: DW'($signed(r_smp_rd[31:16]))};
            end
            S_RB:  rd_addr = {r_inv, addr_b};
            S_WA:  we = 1'b1;
            S_WB: begin
                we      = 1'b1;
                wr_addr = {r_inv, addr_b};
                wr_data = '{re: r_a.re - r_tr, im: r_a.im - r_ti};
            end
            S_LRD: rd_addr = {1'b0, r_idx};
            S_LSQ2: begin
                we      = (m2 == 46'd0);
                wr_addr = {1'b1, bit_rev(r_idx, lg)};
                wr_data = '{re: -(DW'(64'sd2147483648)), im: '0};
            end
            S_LLN1: begin
                we      = 1'b1;
                wr_addr = {1'b1, bit_rev(r_idx, lg)};
                wr_data = '{re: ln_full[DW-1:0], im: '0};
            end
            S_ORD: rd_addr = {1'b1, r_idx};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    // Shared multiplier operand selection
    always_comb begin
        mul_a = r_b.re;
        mul_b = 24'(wr);
        case (r_state)
            S_BF2:  begin mul_a = r_b.im; mul_b = 24'(wi); end
            S_BF3:  begin mul_a = r_b.re; mul_b = 24'(wi); end
            S_BF4:  begin mul_a = r_b.im; mul_b = 24'(wr); end
            S_LSQ0: begin mul_a = r_rd.re; mul_b = r_rd.re[23:0]; end
            S_LSQ1: begin mul_a = r_b.im; mul_b = r_b.im[23:0]; end
            S_LFR0: begin
                mul_a = DW'(t_hi - t_lo);
                mul_b = {12'd0, r_norm[40:29]};
            end
            S_LLN0: begin mul_a = DW'(r_l2); mul_b = 24'sd22713; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Log magnitude helpers
    always_comb begin
        m2      = r_acc[45:0] + r_prod[45:0];
        fk      = r_norm[44:41];
        t_lo    = log2_tab({1'b0, fk});
        t_hi    = log2_tab(5'({1'b0, fk} + 5'd1));
        frac    = t_lo + 17'((r_prod + 64'sd2048) >>> 12);
        ln_full = (r_prod + 64'sd32768) >>> 16;
    end

    // Output scaling by 1/N, rounded half up
    always_comb begin
        o_sum_re = (DW+1)'(r_rd.re) + ((DW+1)'(1) << (lg - 3'd1));
        o_sum_im = (DW+1)'(r_rd.im) + ((DW+1)'(1) << (lg - 3'd1));
        o_q_re   = o_sum_re >>> lg;
        o_q_im   = o_sum_im >>> lg;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pts_log2 <= PTS_LOG2_RESET;
            r_load     <= '0;
            r_bf       <= '0;
            r_idx      <= '0;
            r_stage    <= '0;
            r_inv      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_pts_log2 <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (r_load < n_pts) r_load <= r_load + (IW+1)'(1);
                        if (i_in_data.frame_last) begin
                            r_state <= S_CRD;
                            r_idx   <= '0;
                            r_inv   <= 1'b0;
                            r_stage <= '0;
                            r_bf    <= '0;
                        end
                    end
                end
                // copy samples into bank 0 in reversed order
                S_CRD: r_state <= S_CWR;
                S_CWR: begin
                    if (idx_last) begin
                        r_state <= S_RA;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_CRD;
                    end
                end
                S_RA:  r_state <= S_RB;
                S_RB: begin
                    r_a     <= r_rd;
                    r_state <= S_BF0;
                end
                S_BF0: begin
                    r_b     <= r_rd;
                    r_state <= S_BF1;
                end
                S_BF1: r_state <= S_BF2;
                S_BF2: begin
                    r_acc   <= r_prod;
                    r_state <= S_BF3;
                end
                S_BF3: begin
                    r_tr    <= rnd15(r_acc - r_prod);
                    r_state <= S_BF4;
                end
                S_BF4: begin
                    r_acc   <= r_prod;
                    r_state <= S_BF5;
                end
                S_BF5: begin
                    r_ti    <= rnd15(r_acc + r_prod);
                    r_state <= S_WA;
                end
                S_WA:  r_state <= S_WB;
                S_WB: begin
                    r_state <= S_RA;
                    if (bf_last) begin
                        r_bf <= '0;
                        if (stage_last) begin
                            r_stage <= '0;
                            r_idx   <= '0;
                            r_state <= r_inv ? S_ORD : S_LRD;
                        end else begin
                            r_stage <= r_stage + 3'd1;
                        end
                    end else begin
                        r_bf <= r_bf + IW'(1);
                    end
                end
                // log magnitude pass, bank 0 into bank 1 in reversed order
                S_LRD: r_state <= S_LSQ0;
                S_LSQ0: begin
                    r_b     <= r_rd;
                    r_state <= S_LSQ1;
                end
                S_LSQ1: begin
                    r_acc   <= r_prod;
                    r_state <= S_LSQ2;
                end
                S_LSQ2: begin
                    r_norm <= m2;
                    r_e    <= 6'd45;
                    if (m2 == 46'd0) begin
                        r_state <= S_LWN;
                    end else begin
                        r_state <= S_LNRM;
                    end
                end
                S_LNRM: begin
                    if (r_norm[45:42] == 4'd0) begin
                        r_norm <= r_norm << 4;
                        r_e    <= r_e - 6'd4;
                    end else if (!r_norm[45]) begin
                        r_norm <= r_norm << 1;
                        r_e    <= r_e - 6'd1;
                    end else begin
                        r_state <= S_LFR0;
                    end
                end
                S_LFR0: r_state <= S_LFR1;
                S_LFR1: begin
                    r_l2    <= $signed({r_e, 16'd0} + {7'd0, frac}) - 24'sd1966080;
                    r_state <= S_LLN0;
                end
                S_LLN0: r_state <= S_LLN1;
                S_LLN1: r_state <= S_LWN;
                // next bin, or start the inverse transform on bank 1
                S_LWN: begin
                    if (idx_last) begin
                        r_idx   <= '0;
                        r_inv   <= 1'b1;
                        r_stage <= '0;
                        r_bf    <= '0;
                        r_state <= S_RA;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_LRD;
                    end
                end
                S_ORD: r_state <= S_OWT;
                S_OWT: begin
                    r_out   <= '{coef_re: sat32(o_q_re), coef_im: sat32(o_q_im),
                                 coef_last: idx_last};
                    r_ov    <= 1'b1;
                    r_state <= S_OHLD;
                end
                S_OHLD: begin
                    if (out_xfer) begin
                        r_ov <= 1'b0;
                        if (idx_last) begin
                            r_load  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `RCF_IMPLY(a_ov_in_hold, r_ov, r_state == S_OHLD, "result shown outside hold state")
    `RCF_ASSERT(a_load_bound, r_load <= n_pts, "load count past frame length")
    `RCF_NEXT(a_last_starts, in_xfer && i_in_data.frame_last, r_state == S_CRD,
        "last sample did not start the transform")
    `RCF_IMPLY(a_ov_fall, $fell(o_out_valid), $past(!i_out_stall), "result dropped unaccepted")

endmodule
`default_nettype wire
